// ===== src/scs_pkg.sv =====
// shared types and constants for the segmented cumulative scan
package scs_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int OP_WIDTH   = 2;
   localparam int USER_WIDTH = 2;

   // tuser bit positions on the request channel
   localparam int USER_MISSING_BIT = 0;
   localparam int USER_START_BIT   = 1;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SUM     = 2'd0,
      OP_PRODUCT = 2'd1,
      OP_MIN     = 2'd2,
      OP_MAX     = 2'd3
   } scs_op_type;

   typedef enum logic [1:0] {
      KIND_ZERO    = 2'd0,
      KIND_HOLD    = 2'd1,
      KIND_PASS    = 2'd2,
      KIND_COMBINE = 2'd3
   } scs_kind_type;

   typedef struct packed {
      scs_kind_type          kind;
      logic [DATA_WIDTH-1:0] value;
   } scs_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } scs_fifo_status_type;

endpackage

// ===== src/scs_front.sv =====
// front end: accepts request transactions and classifies them against group state
module scs_front
   import scs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,
   input  logic [USER_WIDTH-1:0] req_tuser,
   input  scs_fifo_status_type   fifo_status,
   output logic                  push,
   output scs_item_type          push_item
);

   logic awaiting_ff;
   logic awaiting_in;
   logic missing;
   logic start;
   logic awaiting_now;

   assign missing      = req_tuser[USER_MISSING_BIT];
   assign start        = req_tuser[USER_START_BIT];
   assign awaiting_now = start | awaiting_ff;

   assign req_tready = ~fifo_status.full;
   assign push       = req_tvalid & req_tready;

   always_comb begin
      push_item.value = req_tdata;
      if (missing) begin
         push_item.kind = start ? KIND_ZERO : KIND_HOLD;
      end else if (awaiting_now) begin
         push_item.kind = KIND_PASS;
      end else begin
         push_item.kind = KIND_COMBINE;
      end
   end

   always_comb begin
      awaiting_in = awaiting_ff;
      if (push) begin
         awaiting_in = awaiting_now & missing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
      end else begin
         awaiting_ff <= awaiting_in;
      end
   end

endmodule

// ===== src/scs_fifo.sv =====
// short queue of classified items between front and back
module scs_fifo
   import scs_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scs_item_type        push_item,
   input  logic                pop,
   output scs_item_type        pop_item,
   output scs_fifo_status_type status
);

   localparam int PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   scs_item_type         mem_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_in;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [CNT_WIDTH-1:0] cnt_in;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] ptr);
      if (ptr == PTR_WIDTH'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_WIDTH'(1);
   endfunction

   assign status.full  = (cnt_ff == CNT_WIDTH'(FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== src/scs_back.sv =====
// back end: accumulator update, operation register and response output register
module scs_back
   import scs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [OP_WIDTH-1:0]   csr_wdata,
   input  scs_fifo_status_type   fifo_status,
   input  scs_item_type          pop_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata
);

   scs_op_type            op_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [DATA_WIDTH-1:0] acc_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic [DATA_WIDTH-1:0] combined;
   logic [DATA_WIDTH-1:0] product;
   logic                  x_less;

   assign pop        = ~fifo_status.empty & (~rsp_valid_ff | rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign product = acc_ff * pop_item.value;
   assign x_less  = $signed(pop_item.value) < $signed(acc_ff);

   always_comb begin
      case (op_ff)
         OP_SUM:     combined = acc_ff + pop_item.value;
         OP_PRODUCT: combined = product;
         OP_MIN:     combined = x_less ? pop_item.value : acc_ff;
         OP_MAX:     combined = (!x_less && pop_item.value != acc_ff) ? pop_item.value : acc_ff;
         default:    combined = acc_ff;
      endcase
   end

   always_comb begin
      case (pop_item.kind)
         KIND_ZERO:    acc_in = '0;
         KIND_HOLD:    acc_in = acc_ff;
         KIND_PASS:    acc_in = pop_item.value;
         KIND_COMBINE: acc_in = combined;
         default:      acc_in = acc_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_SUM;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            op_ff <= scs_op_type'(csr_wdata);
         end
         if (pop) begin
            acc_ff <= acc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/segmented_cumulative_scan.sv =====
// segmented running sum, product, minimum or maximum over a grouped stream
//
// request channel (req_*): one signed value per transaction, with tuser flags
// for a missing value and for the start of a new group. response channel
// (rsp_*): exactly one running result per request, in order.
// csr_wen/csr_wdata write the operation: sum, product, minimum or maximum;
// write it only while no transaction is in flight.
// each response passes through the queue and then the output register after
// its request is accepted. throughput: one transaction per cycle while the
// response side is ready, set by the accumulator update (one 32x32 multiply
// for products).
// the front end tracks group state and pushes classified items into a
// FIFO_DEPTH entry queue; the back end drains it into the output register.
// when rsp_tready is low the output register holds, the queue fills and
// req_tready drops once it is full.
// reset clears the queue, sets the operation to sum, the running result to
// zero and marks the current group as waiting for its first real value.
module segmented_cumulative_scan
   import scs_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [OP_WIDTH-1:0]   csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // [31:0] value
   input  logic [USER_WIDTH-1:0] req_tuser,   // [0] is_missing, [1] group_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata    // [31:0] running_result
);

   scs_fifo_status_type fifo_status;
   scs_item_type        push_item;
   scs_item_type        pop_item;
   logic                push;
   logic                pop;

   scs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .fifo_status (fifo_status),
      .push        (push),
      .push_item   (push_item)
   );

   scs_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (fifo_status)
   );

   scs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .fifo_status (fifo_status),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== src/scs_checker.sv =====
// port-level checker for the segmented cumulative scan, bound to the top level
module scs_checker
   import scs_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_WIDTH-1:0] rsp_tdata
);

   localparam int OUT_WIDTH = $clog2(FIFO_DEPTH + 3);

   logic [OUT_WIDTH-1:0] outstanding_ff;
   logic [OUT_WIDTH-1:0] outstanding_in;
   logic                 req_xfer;
   logic                 rsp_xfer;

   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_tvalid & rsp_tready;
   assign outstanding_in = outstanding_ff + OUT_WIDTH'(req_xfer) - OUT_WIDTH'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // no response without an accepted request behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> outstanding_ff != '0)
      else $error("response with no request outstanding");

   // queue plus output register bound the transactions in flight
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OUT_WIDTH'(FIFO_DEPTH + 1))
      else $error("more transactions in flight than storage");

endmodule

bind segmented_cumulative_scan scs_checker #(
   .FIFO_DEPTH (FIFO_DEPTH)
) u_scs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
